FILE: sv/pbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Perceptron predictor package
// Shared constants and types for the perceptron branch predictor.
// ----------------------------------------------------------------------------
package pbp_pkg;

   localparam int unsigned SUM_WIDTH = 14;
   localparam int unsigned THRESH_WIDTH = 13;
   localparam int unsigned LIMIT_WIDTH = 7;
   localparam int unsigned ADDR_WIDTH = 64;
   localparam int unsigned FOLD_SHIFT = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRAIN_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WEIGHT_LIMIT = 2'd1;

   localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 13'd75;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 7'd127;

   typedef enum logic [1:0] {
      BE_CLEAR,
      BE_READ,
      BE_EVAL,
      BE_WRITE
   } be_state_type;

endpackage : pbp_pkg
`default_nettype wire

FILE: sv/pbp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Perceptron predictor front end
// Accepts resolved branches, folds the address to a row index and queues them.
// ----------------------------------------------------------------------------
module pbp_front
   import pbp_pkg::*;
#(
   parameter int unsigned ROW_BITS = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  wire  [ADDR_WIDTH-1:0] in_addr,
   input  wire                   in_taken,
   output logic                  q_valid,
   input  wire                   q_ready,
   output logic [ROW_BITS-1:0]   q_row,
   output logic                  q_taken
);

   logic [1:0]          count_ff, count_in;
   logic                rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [ROW_BITS:0]   entry_ff [2];
   logic [ADDR_WIDTH-1:0] folded;
   logic                push, pop;

   assign folded   = in_addr ^ (in_addr >> FOLD_SHIFT);
   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_row    = entry_ff[rd_ptr_ff][ROW_BITS-1:0];
   assign q_taken  = entry_ff[rd_ptr_ff][ROW_BITS];

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {in_taken, folded[ROW_BITS-1:0]};
      end
   end

endmodule : pbp_front
`default_nettype wire

FILE: sv/pbp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Perceptron predictor back end
// Reads a weight row, forms the dot product and, when it trains, writes the row back.
// ----------------------------------------------------------------------------
module pbp_back
   import pbp_pkg::*;
#(
   parameter int unsigned HISTORY_BITS = 32,
   parameter int unsigned ROW_BITS     = 8,
   parameter int unsigned WEIGHT_BITS  = 8
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [THRESH_WIDTH-1:0] threshold,
   input  wire  [LIMIT_WIDTH-1:0]  limit,
   input  wire                     q_valid,
   output logic                    q_ready,
   input  wire  [ROW_BITS-1:0]     q_row,
   input  wire                     q_taken,
   output logic                    out_valid,
   input  wire                     out_ready,
   output logic [SUM_WIDTH+2:0]    out_data
);

   localparam int unsigned ROWS = 1 << ROW_BITS;
   localparam int unsigned ROW_LEN = HISTORY_BITS + 1;
   localparam int unsigned ROW_WIDTH = ROW_LEN * WEIGHT_BITS;
   localparam int unsigned SW = WEIGHT_BITS + 7;
   localparam int unsigned CAP = (1 << (WEIGHT_BITS - 1)) - 1;
   localparam int unsigned TERMS = 1 << $clog2(ROW_LEN);
   localparam logic signed [WEIGHT_BITS+1:0] W_ONE = (WEIGHT_BITS + 2)'(1);

   be_state_type state_ff, state_in;
   logic [ROW_WIDTH-1:0]    mem [ROWS];
   logic [ROW_WIDTH-1:0]    rdata_ff, wdata_ff;
   logic [ROW_BITS-1:0]     row_ff, clr_ff;
   logic                    taken_ff;
   logic [HISTORY_BITS-1:0] hist_ff;
   logic                    train_ff;
   logic                    out_valid_ff;
   logic [SUM_WIDTH+2:0]    out_data_ff;
   logic signed [SW-1:0]    terms_c [TERMS];
   logic signed [SW-1:0]    sum_c, mag_c;
   logic                    pred_c, miss_c, train_c;
   logic [ROW_WIDTH-1:0]    new_row_c;
   logic                    mem_we;
   logic [ROW_BITS-1:0]     mem_waddr;
   logic [ROW_WIDTH-1:0]    mem_wdata;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BE_CLEAR: if (clr_ff == ROW_BITS'(ROWS - 1)) state_in = BE_READ;
         BE_READ:  if (q_valid) state_in = BE_EVAL;
         BE_EVAL:  if (!out_valid_ff || out_ready) state_in = BE_WRITE;
         BE_WRITE: state_in = BE_READ;
         default:  state_in = BE_CLEAR;
      endcase
   end

   always_comb begin
      q_ready   = (state_ff == BE_READ);
      mem_we    = (state_ff == BE_CLEAR) || (state_ff == BE_WRITE && train_ff);
      mem_waddr = (state_ff == BE_CLEAR) ? clr_ff : row_ff;
      mem_wdata = (state_ff == BE_CLEAR) ? '0 : wdata_ff;
   end

   // Dot product over the row as a balanced adder tree, done in the evaluation cycle.
   always_comb begin
      for (int i = 0; i < TERMS; i++) terms_c[i] = '0;
      terms_c[0] = SW'(signed'(rdata_ff[WEIGHT_BITS-1:0]));
      for (int i = 0; i < HISTORY_BITS; i++) begin
         if (hist_ff[i]) terms_c[i+1] = SW'(signed'(rdata_ff[(i+1)*WEIGHT_BITS +: WEIGHT_BITS]));
         else terms_c[i+1] = -SW'(signed'(rdata_ff[(i+1)*WEIGHT_BITS +: WEIGHT_BITS]));
      end
      for (int span = TERMS >> 1; span > 0; span = span >> 1) begin
         for (int i = 0; i < span; i++) terms_c[i] = terms_c[2*i] + terms_c[2*i+1];
      end
      sum_c   = terms_c[0];
      pred_c  = !sum_c[SW-1];
      miss_c  = (pred_c != taken_ff);
      mag_c   = sum_c[SW-1] ? -sum_c : sum_c;
      train_c = miss_c || (mag_c <= signed'(SW'(threshold)));
   end

   always_comb begin
      logic signed [WEIGHT_BITS+1:0] w, b;
      logic                          up;
      b = (WEIGHT_BITS + 2)'((int'(limit) > int'(CAP)) ? int'(CAP) : int'(limit));
      for (int i = 0; i < ROW_LEN; i++) begin
         up = (i == 0) ? taken_ff : (hist_ff[i-1] == taken_ff);
         w  = (WEIGHT_BITS + 2)'(signed'(rdata_ff[i*WEIGHT_BITS +: WEIGHT_BITS]));
         w  = up ? w + W_ONE : w - W_ONE;
         if (w > b) w = b;
         if (w < -b) w = -b;
         new_row_c[i*WEIGHT_BITS +: WEIGHT_BITS] = w[WEIGHT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_CLEAR;
         clr_ff       <= '0;
         hist_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BE_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == BE_EVAL && state_in == BE_WRITE) begin
            hist_ff      <= {hist_ff[HISTORY_BITS-2:0], taken_ff};
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BE_READ && q_valid) begin
         row_ff   <= q_row;
         taken_ff <= q_taken;
         rdata_ff <= mem[q_row];
      end
      if (state_ff == BE_EVAL && state_in == BE_WRITE) begin
         wdata_ff    <= new_row_c;
         train_ff    <= train_c;
         out_data_ff <= {train_c, miss_c, sum_c[SUM_WIDTH-1:0], pred_c};
      end
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule : pbp_back
`default_nettype wire

FILE: sv/perceptron_branch_predictor.sv
// A req transaction is queued in the front end; the back end then reads its weight row,
// evaluates it, raising rsp_tvalid, and writes it back if it trains; branches ahead delay it.
// Branches pass one at a time through the read, evaluate and write-back passes over
// the single-port weight memory; a held rsp stalls the evaluate pass.
// Reset is synchronous; afterwards a clearing pass over all TABLE_ROWS rows zeroes
// the weight memory while up to two accepted branches wait in the front queue.
`default_nettype none
// ----------------------------------------------------------------------------
// Perceptron branch predictor
// Global-history perceptron predictor trained on resolved branches.
// ----------------------------------------------------------------------------
module perceptron_branch_predictor
   import pbp_pkg::*;
#(
   parameter int unsigned HISTORY_BITS = 32,
   parameter int unsigned TABLE_ROWS   = 256,
   parameter int unsigned WEIGHT_BITS  = 8
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [71:0] req_tdata,  // branch_address[63:0], actual_taken[64]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,  // predicted_taken, output_sum[14:1], mispredicted, trained
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [15:0] csr_data
);

   localparam int unsigned ROW_BITS = $clog2(TABLE_ROWS);

   logic [THRESH_WIDTH-1:0] thresh_ff;
   logic [LIMIT_WIDTH-1:0]  limit_ff;
   logic                    q_valid, q_ready, q_taken;
   logic [ROW_BITS-1:0]     q_row;
   logic [SUM_WIDTH+2:0]    out_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TRAIN_THRESHOLD: thresh_ff <= csr_data[THRESH_WIDTH-1:0];
            CSR_WEIGHT_LIMIT:    limit_ff  <= csr_data[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   pbp_front #(.ROW_BITS(ROW_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_addr  (req_tdata[63:0]),
      .in_taken (req_tdata[64]),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_row    (q_row),
      .q_taken  (q_taken)
   );

   pbp_back #(
      .HISTORY_BITS (HISTORY_BITS),
      .ROW_BITS     (ROW_BITS),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .threshold (thresh_ff),
      .limit     (limit_ff),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_row     (q_row),
      .q_taken   (q_taken),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {7'd0, out_data};

endmodule : perceptron_branch_predictor
`default_nettype wire

FILE: sv/pbp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Perceptron predictor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module pbp_assertions (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [23:0] rsp_tdata
);

   // A mispredict must always train.
   a_miss_trains: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15] |-> rsp_tdata[16]) else $error("miss without train");

   // Prediction matches the sign of the sum.
   a_pred_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == !rsp_tdata[14])) else $error("pred/sum mismatch");

   // A stalled transaction holds its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp dropped");

   // No response right after reset.
   a_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid) else $error("rsp after reset");

   // Padding bits stay zero.
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:17] == 7'd0) else $error("pad nonzero");

endmodule : pbp_assertions

bind perceptron_branch_predictor pbp_assertions u_pbp_assertions (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
